@@ hdl/ptq_pkg.sv @@
// Package for the priority task queue: queue depth, request and response
// payload types, status codes and the cell control structures.
// No dependencies.
package ptq_pkg;

	localparam int QUEUE_DEPTH = 16;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_RUN    = 1'b1;

	localparam logic [1:0] STATUS_INSERTED = 2'd0;
	localparam logic [1:0] STATUS_FULL     = 2'd1;
	localparam logic [1:0] STATUS_DRAINED  = 2'd2;
	localparam logic [1:0] STATUS_EMPTY    = 2'd3;

	typedef struct packed {
		logic       req_type;
		logic [7:0] task_handle;
		logic [7:0] task_priority;
	} ptq_req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] out_handle;
		logic [7:0] out_priority;
		logic       last;
	} ptq_rsp_t;

	typedef struct packed {
		logic [7:0] handle;
		logic [7:0] prio;
	} ptq_entry_t;

	// Broadcast to every cell of the chain in each cycle.
	typedef struct packed {
		logic       insert;
		logic       shift;
		ptq_entry_t new_entry;
	} ptq_cell_ctl_t;

	// What the controller sees of the chain.
	typedef struct packed {
		ptq_entry_t head;
		logic       head_valid;
		ptq_entry_t next;
		logic       next_valid;
		logic       full;
	} ptq_chain_sts_t;

endpackage

@@ hdl/ptq_cell.sv @@
// One slot of the sorted chain: holds an entry and its valid bit, and
// either keeps them or takes the new entry, its left neighbor's entry, or its right one.
// Depends on ptq_pkg.
module ptq_cell import ptq_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  ptq_cell_ctl_t ctl,
	input  ptq_entry_t    left_entry,
	input  logic          left_valid,
	input  logic          left_ins,
	input  ptq_entry_t    right_entry,
	input  logic          right_valid,
	output ptq_entry_t    entry,
	output logic          valid,
	output logic          ins
);

	ptq_entry_t entry_q;
	logic       valid_q;
	ptq_entry_t entry_d;
	logic       valid_d;

	// This slot lies at or behind the insertion point.
	assign ins = !valid_q || (entry_q.prio > ctl.new_entry.prio);

	always_comb begin
		entry_d = entry_q;
		valid_d = valid_q;
		if (ctl.insert) begin
			if (ins && left_ins) begin
				entry_d = left_entry;
				valid_d = left_valid;
			end else if (ins) begin
				entry_d = ctl.new_entry;
				valid_d = 1'b1;
			end
		end else if (ctl.shift) begin
			entry_d = right_entry;
			valid_d = right_valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

	assign entry = entry_q;
	assign valid = valid_q;

endmodule

@@ hdl/ptq_chain.sv @@
// Row of QUEUE_DEPTH cells kept in ascending priority order, head at cell 0.
// Depends on ptq_pkg and ptq_cell.
module ptq_chain import ptq_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  ptq_cell_ctl_t  ctl,
	output ptq_chain_sts_t sts
);

	ptq_entry_t entry [QUEUE_DEPTH];
	logic       valid [QUEUE_DEPTH];
	logic       ins   [QUEUE_DEPTH];

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		ptq_entry_t l_entry;
		logic       l_valid;
		logic       l_ins;
		ptq_entry_t r_entry;
		logic       r_valid;

		if (i == 0) begin : g_first
			assign l_entry = '0;
			assign l_valid = 1'b0;
			assign l_ins   = 1'b0;
		end else begin : g_mid_l
			assign l_entry = entry[i-1];
			assign l_valid = valid[i-1];
			assign l_ins   = ins[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign r_entry = '0;
			assign r_valid = 1'b0;
		end else begin : g_mid_r
			assign r_entry = entry[i+1];
			assign r_valid = valid[i+1];
		end

		ptq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.left_entry  (l_entry),
			.left_valid  (l_valid),
			.left_ins    (l_ins),
			.right_entry (r_entry),
			.right_valid (r_valid),
			.entry       (entry[i]),
			.valid       (valid[i]),
			.ins         (ins[i])
		);
	end

	assign sts.head       = entry[0];
	assign sts.head_valid = valid[0];
	assign sts.next       = entry[1];
	assign sts.next_valid = valid[1];
	assign sts.full       = valid[QUEUE_DEPTH-1];

endmodule

@@ hdl/priority_task_queue.sv @@
// Priority task queue: a sorted chain of cells with a request controller
// and a registered response stage. Depends on ptq_pkg and ptq_chain.
//
// Usage:
//   Requests arrive on req/req_valid/req_stall, responses leave on
//   rsp/rsp_valid/rsp_stall. A request moves when valid is high and stall low.
//   An insert places the task behind all waiting entries of lower or equal
//   priority number; its response (inserted or full) appears in the response
//   register the next cycle. A run returns every queued entry head first, one
//   response per cycle unless the receiver stalls, last set on the final one;
//   a run on an empty queue returns one empty response. Inserts sustain one
//   per cycle unless the receiver stalls. A run of more than one entry holds
//   the request side while the chain shifts one cell toward the head per cycle.
//   While the receiver stalls a valid response, the response register holds
//   and no new request is taken, nor does a drain advance.
//   Reset clears all valid bits of the chain, so the queue starts empty; no
//   clearing pass is needed.
module priority_task_queue import ptq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  ptq_req_t req,
	input  logic     req_valid,
	output logic     req_stall,
	output ptq_rsp_t rsp,
	output logic     rsp_valid,
	input  logic     rsp_stall
);

	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_DRAIN = 1'b1;

	logic           state_q;
	logic           state_d;
	ptq_rsp_t       rsp_q;
	ptq_rsp_t       rsp_d;
	logic           rsp_valid_q;
	logic           out_free;
	logic           req_fire;
	logic           is_run;
	logic           drain_pop;
	logic           load;
	ptq_cell_ctl_t  ctl;
	ptq_chain_sts_t sts;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q == ST_DRAIN) || !out_free;
	assign req_fire  = req_valid && !req_stall;
	assign is_run    = (req.req_type == REQ_RUN);

	assign drain_pop = (req_fire && is_run && sts.head_valid)
		|| ((state_q == ST_DRAIN) && out_free);
	assign load      = req_fire || drain_pop;

	assign ctl.insert    = req_fire && !is_run && !sts.full;
	assign ctl.shift     = drain_pop;
	assign ctl.new_entry = '{handle: req.task_handle, prio: req.task_priority};

	always_comb begin
		rsp_d = '0;
		rsp_d.last = 1'b1;
		if (drain_pop) begin
			rsp_d.status       = STATUS_DRAINED;
			rsp_d.out_handle   = sts.head.handle;
			rsp_d.out_priority = sts.head.prio;
			rsp_d.last         = !sts.next_valid;
		end else begin
			case (req.req_type)
				REQ_INSERT: rsp_d.status = sts.full ? STATUS_FULL : STATUS_INSERTED;
				default:    rsp_d.status = STATUS_EMPTY;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_fire && is_run && sts.head_valid && sts.next_valid) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (drain_pop && !sts.next_valid) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q <= rsp_d;
		end
	end

	ptq_chain u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.sts    (sts)
	);

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

`ifndef SYNTH
	// A drain in progress always has an entry at the head.
	a_drain_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> sts.head_valid)
		else $error("drain state with empty chain");

	// The head never carries a larger priority number than its successor.
	a_head_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		(sts.head_valid && sts.next_valid) |-> (sts.head.prio <= sts.next.prio))
		else $error("chain head out of order");

	// Every accepted request puts a response in the output register.
	a_req_gets_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> rsp_valid)
		else $error("accepted request produced no response");

	// An accepted insert leaves the queue non-empty.
	a_insert_fills: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.insert |=> sts.head_valid)
		else $error("insert did not fill the chain");
`endif

endmodule

@@ verif/tb_priority_task_queue.sv @@
`timescale 1ns / 1ps
// Testbench for priority_task_queue: directed and random request traffic checked
// against a sorted shadow queue. Depends on ptq_pkg and the priority_task_queue RTL.
module tb_priority_task_queue;
	import ptq_pkg::*;

	logic     clk;
	logic     arst_n;
	ptq_req_t req;
	logic     req_valid;
	logic     req_stall;
	ptq_rsp_t rsp;
	logic     rsp_valid;
	logic     rsp_stall;

	// Entries the queue should hold, head first, and the responses still owed.
	ptq_entry_t shadow_queue[$];
	ptq_rsp_t   awaited_rsps[$];

	int  error_count;
	bit  req_gaps_on;
	bit  rsp_stalls_on;
	int  stall_left;

	priority_task_queue DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.rsp      (rsp),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("** priority_task_queue: FAILED **");
		$finish;
	end

	task automatic report_mismatch(string what, int got, int want);
		$display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		error_count++;
	endtask

	function automatic int pick_idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 8);
		return $urandom_range(12, 40);
	endfunction

	// Works out the responses of one accepted request and updates the shadow queue.
	task automatic apply_request(ptq_req_t r);
		ptq_rsp_t   rs;
		ptq_entry_t e;
		int         pos;
		int         n;
		rs = '0;
		if (r.req_type == REQ_INSERT) begin
			if (shadow_queue.size() >= QUEUE_DEPTH) begin
				rs.status = STATUS_FULL;
			end else begin
				// Behind every entry of lower or equal priority number.
				pos = shadow_queue.size();
				for (int i = shadow_queue.size() - 1; i >= 0; i--) begin
					if (shadow_queue[i].prio > r.task_priority)
						pos = i;
				end
				e.handle = r.task_handle;
				e.prio   = r.task_priority;
				shadow_queue.insert(pos, e);
				rs.status = STATUS_INSERTED;
			end
			rs.last = 1'b1;
			awaited_rsps.push_back(rs);
		end else if (shadow_queue.size() == 0) begin
			rs.status = STATUS_EMPTY;
			rs.last   = 1'b1;
			awaited_rsps.push_back(rs);
		end else begin
			n = shadow_queue.size();
			for (int i = 0; i < n; i++) begin
				rs.status       = STATUS_DRAINED;
				rs.out_handle   = shadow_queue[i].handle;
				rs.out_priority = shadow_queue[i].prio;
				rs.last         = (i == n - 1);
				awaited_rsps.push_back(rs);
			end
			shadow_queue.delete();
		end
	endtask

	// Drives one request from a falling edge and returns at the falling edge after it is taken.
	task automatic send_request(logic kind, logic [7:0] handle, logic [7:0] prio);
		ptq_req_t r;
		int       gap;
		r.req_type      = kind;
		r.task_handle   = handle;
		r.task_priority = prio;
		gap = (req_gaps_on && $urandom_range(0, 99) < 30) ? pick_idle_len() : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req       <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall !== 1'b0)
			@(posedge clk);
		apply_request(r);
		@(negedge clk);
	endtask

	task automatic wait_for_responses();
		int waited;
		waited = 0;
		req_valid <= 1'b0;
		while (awaited_rsps.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
	endtask

	// Receiver side: stall runs of random length; no new run starts while stalls are switched off.
	initial begin
		rsp_stall  = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
				if (rsp_stalls_on && $urandom_range(0, 99) < 25)
					stall_left = pick_idle_len();
			end
		end
	end

	// Response checker: every accepted response against the oldest expectation.
	initial begin
		ptq_rsp_t want;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
				if (awaited_rsps.size() == 0) begin
					report_mismatch("unexpected response", rsp, 0);
				end else begin
					want = awaited_rsps.pop_front();
					if (rsp.status !== want.status)
						report_mismatch("status", rsp.status, want.status);
					if (rsp.out_handle !== want.out_handle)
						report_mismatch("out_handle", rsp.out_handle, want.out_handle);
					if (rsp.out_priority !== want.out_priority)
						report_mismatch("out_priority", rsp.out_priority, want.out_priority);
					if (rsp.last !== want.last)
						report_mismatch("last", rsp.last, want.last);
				end
			end
		end
	end

	// Empty run, field extremes, equal priorities, overflow, and a run with task fields set.
	task automatic test_directed_cases();
		req_gaps_on   = 1'b0;
		rsp_stalls_on = 1'b0;
		send_request(REQ_RUN, 8'h00, 8'h00);
		send_request(REQ_INSERT, 8'h00, 8'h00);
		send_request(REQ_INSERT, 8'hFF, 8'hFF);
		send_request(REQ_INSERT, 8'h11, 8'h80);
		send_request(REQ_INSERT, 8'h22, 8'h80);
		send_request(REQ_INSERT, 8'h33, 8'h80);
		send_request(REQ_INSERT, 8'h44, 8'h00);
		send_request(REQ_INSERT, 8'h55, 8'hFF);
		send_request(REQ_INSERT, 8'h66, 8'h7F);
		send_request(REQ_INSERT, 8'h77, 8'h81);
		send_request(REQ_INSERT, 8'h88, 8'h01);
		send_request(REQ_INSERT, 8'h99, 8'hFE);
		send_request(REQ_INSERT, 8'hA5, 8'h5A);
		send_request(REQ_INSERT, 8'h5A, 8'hA5);
		send_request(REQ_INSERT, 8'hC3, 8'h3C);
		send_request(REQ_INSERT, 8'h3C, 8'hC3);
		send_request(REQ_INSERT, 8'hF0, 8'h0F);
		// The queue is full now; this one would land behind the two priority-0 entries if it were taken.
		send_request(REQ_INSERT, 8'hEE, 8'h00);
		send_request(REQ_RUN, 8'hAA, 8'h55);
		send_request(REQ_RUN, 8'hFF, 8'hFF);
		send_request(REQ_INSERT, 8'h01, 8'h02);
		send_request(REQ_RUN, 8'h00, 8'h00);
		wait_for_responses();
	endtask

	// Full-rate traffic with no idling on either side.
	task automatic test_back_to_back();
		req_gaps_on   = 1'b0;
		rsp_stalls_on = 1'b0;
		for (int k = 0; k < 4; k++) begin
			repeat ($urandom_range(4, QUEUE_DEPTH + 2))
				send_request(REQ_INSERT, 8'($urandom), 8'($urandom));
			send_request(REQ_RUN, 8'($urandom), 8'($urandom));
			send_request(REQ_RUN, 8'($urandom), 8'($urandom));
		end
		wait_for_responses();
	endtask

	// Mostly insert bursts closed by a run, with some stray requests in between.
	task automatic test_random_traffic(int n_items);
		int sent;
		int burst;
		bit ties;
		sent = 0;
		while (sent < n_items) begin
			req_gaps_on   = ($urandom_range(0, 99) < 85);
			rsp_stalls_on = ($urandom_range(0, 99) < 85);
			if ($urandom_range(0, 99) < 80) begin
				if ($urandom_range(0, 9) == 0)
					burst = $urandom_range(QUEUE_DEPTH, QUEUE_DEPTH + 3);
				else
					burst = $urandom_range(1, QUEUE_DEPTH - 1);
				// A small set of priorities forces plenty of equal-priority entries.
				ties = ($urandom_range(0, 2) == 0);
				repeat (burst) begin
					send_request(REQ_INSERT, 8'($urandom),
						ties ? 8'($urandom_range(0, 3) * 85) : 8'($urandom));
					sent++;
				end
				send_request(REQ_RUN, 8'($urandom), 8'($urandom));
				sent++;
			end else begin
				send_request(1'($urandom), 8'($urandom), 8'($urandom));
				sent++;
			end
		end
		wait_for_responses();
	endtask

	initial begin
		arst_n        = 1'b0;
		req           = '0;
		req_valid     = 1'b0;
		error_count   = 0;
		req_gaps_on   = 1'b0;
		rsp_stalls_on = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_cases();
		test_back_to_back();
		test_random_traffic(280);

		if (awaited_rsps.size() != 0)
			report_mismatch("responses left over", awaited_rsps.size(), 0);
		if (error_count == 0) begin
			$display("** priority_task_queue: PASSED **");
		end else begin
			$display("** priority_task_queue: FAILED **");
		end
		$finish;
	end

endmodule
